### hw/rtl/pngu_pkg.sv
`default_nettype none

package pngu_pkg;

  localparam int BYTE_W      = 8;
  localparam int BPP_W       = 3;
  localparam int ROW_BYTES_W = 14;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = ROW_BYTES_W;

  localparam int DEF_MAX_ROW_BYTES = 8192;

  localparam logic [BPP_W-1:0]       BPP_RESET       = 3'd4;
  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RESET = 14'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BPP       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 1'b1;

  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_SUB   = 3'd1;
  localparam logic [2:0] FLT_UP    = 3'd2;
  localparam logic [2:0] FLT_AVG   = 3'd3;
  localparam logic [2:0] FLT_PAETH = 3'd4;

  localparam logic [BYTE_W-1:0] FLT_MAX_CODE = 8'd4;

  typedef logic [BYTE_W-1:0] pix_byte_t;

endpackage

`default_nettype wire

### hw/rtl/pngu_in_if.sv
`default_nettype none

interface pngu_in_if
  import pngu_pkg::*;
();
  logic      valid;
  logic      ready;
  pix_byte_t byte_value;
  logic      image_start;

  modport source (output valid, output byte_value, output image_start, input ready);
  modport sink   (input valid, input byte_value, input image_start, output ready);
endinterface

`default_nettype wire

### hw/rtl/pngu_out_if.sv
`default_nettype none

interface pngu_out_if
  import pngu_pkg::*;
();
  logic      valid;
  logic      ready;
  pix_byte_t pixel_byte;
  logic      row_last;
  logic      filter_error;

  modport source (output valid, output pixel_byte, output row_last, output filter_error,
                  input ready);
  modport sink   (input valid, input pixel_byte, input row_last, input filter_error,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/png_scanline_unfilter.sv
// Channel   | Dir | Payload                                   | Handshake
// stream    | in  | byte_value[7:0], image_start              | valid/ready
// pixels    | out | pixel_byte[7:0], row_last, filter_error   | valid/ready
// wr_*      | in  | wr_index[0], wr_data[13:0]                | wr_en, no wait
//
// One item per cycle while the output is not stalled; an item's result passes through the stage 1 and output registers.
// Stage 0 issues the line-store read, stage 1 rebuilds the byte and writes it back.
// Line store is a single-port-write, registered-read memory; same-address
// read/write in adjacent items is forwarded. No clearing pass after reset.
// Reset (rst, synchronous) clears control state and registers to their defaults.
// Output stall holds a data or error item in stage 1, which holds the input side via ready.

`default_nettype none

module png_scanline_unfilter
  import pngu_pkg::*;
#(
  parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  pngu_in_if.sink                    stream,
  pngu_out_if.source                 pixels,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data
);

  localparam int AW = $clog2(MAX_ROW_BYTES);
  localparam int LW = $clog2(MAX_ROW_BYTES + 1);
  localparam int XW = (LW > ROW_BYTES_W) ? LW : ROW_BYTES_W;

  typedef enum logic [1:0] {K_DATA, K_CLEAR, K_ERR} item_kind_t;

  function automatic pix_byte_t paeth_pred(input pix_byte_t a, input pix_byte_t b,
                                           input pix_byte_t c);
    pix_byte_t   pa;
    pix_byte_t   pb;
    logic [10:0] p;
    logic [9:0]  pc;
    logic [9:0]  pa_x;
    logic [9:0]  pb_x;
    pa   = (b > c) ? b - c : c - b;
    pb   = (a > c) ? a - c : c - a;
    p    = {3'b000, a} + {3'b000, b} - {2'b00, c, 1'b0};
    pc   = p[10] ? 10'(~p + 11'd1) : p[9:0];
    pa_x = {2'b00, pa};
    pb_x = {2'b00, pb};
    if (pa_x <= pb_x && pa_x <= pc) return a;
    else if (pb_x <= pc) return b;
    else return c;
  endfunction

  // configuration
  logic [BPP_W-1:0]       bpp;
  logic [ROW_BYTES_W-1:0] row_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp       <= BPP_RESET;
      row_bytes <= ROW_BYTES_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BPP:       bpp       <= wr_data[BPP_W-1:0];
        REG_ROW_BYTES: row_bytes <= wr_data;
      endcase
    end
  end

  // stage 0 state
  logic [AW-1:0] column_pos, column_pos_next;
  logic [2:0]    row_filter, row_filter_next;
  logic          on_first_row, on_first_row_next;
  logic          expect_filter, expect_filter_next;
  logic          error_latched, error_latched_next;

  // stage 1
  logic          s1_valid;
  item_kind_t    s1_kind;
  logic [AW-1:0] s1_pos;
  logic [2:0]    s1_filter;
  logic          s1_zero_b;
  logic          s1_last;
  pix_byte_t     s1_byte;
  logic          s1_fwd;
  pix_byte_t     s1_fwd_data;
  logic          s1_move;
  logic          s1_we;

  pix_byte_t     line_mem [MAX_ROW_BYTES];
  pix_byte_t     mem_q;

  logic [31:0]   left_pixel;
  logic [31:0]   upper_left_pixel;

  logic          out_valid;
  pix_byte_t     out_byte;
  logic          out_last;
  logic          out_err;

  logic          acc;
  logic          err_eff, first_eff, expf_eff, bad_flt;
  logic [XW-1:0] rb_raw, eff_rb, col_x, pos_x;
  logic [AW-1:0] pos_addr;
  logic          is_last;
  logic          ld_valid;
  item_kind_t    ld_kind;
  logic          rd_en;

  assign acc       = stream.valid && stream.ready;
  assign err_eff   = stream.image_start ? 1'b0 : error_latched;
  assign first_eff = stream.image_start ? 1'b1 : on_first_row;
  assign expf_eff  = stream.image_start ? 1'b1 : expect_filter;
  assign bad_flt   = stream.byte_value > FLT_MAX_CODE;

  assign rb_raw   = XW'(row_bytes);
  assign eff_rb   = (rb_raw == '0) ? XW'(1) :
                    (rb_raw > XW'(MAX_ROW_BYTES)) ? XW'(MAX_ROW_BYTES) : rb_raw;
  assign col_x    = XW'(column_pos);
  assign pos_x    = (col_x < eff_rb) ? col_x : eff_rb - XW'(1);
  assign pos_addr = pos_x[AW-1:0];
  assign is_last  = (pos_x + XW'(1)) >= eff_rb;

  assign ld_valid = !err_eff;
  assign ld_kind  = !expf_eff ? K_DATA : (bad_flt ? K_ERR : K_CLEAR);
  assign rd_en    = acc && !err_eff && !expf_eff;

  always_comb begin
    column_pos_next    = column_pos;
    row_filter_next    = row_filter;
    on_first_row_next  = on_first_row;
    expect_filter_next = expect_filter;
    error_latched_next = error_latched;
    if (acc) begin
      error_latched_next = err_eff;
      on_first_row_next  = first_eff;
      expect_filter_next = expf_eff;
      if (!err_eff) begin
        if (expf_eff) begin
          if (bad_flt) begin
            error_latched_next = 1'b1;
          end else begin
            row_filter_next    = stream.byte_value[2:0];
            expect_filter_next = 1'b0;
            column_pos_next    = '0;
          end
        end else if (is_last) begin
          column_pos_next    = '0;
          expect_filter_next = 1'b1;
          on_first_row_next  = 1'b0;
        end else begin
          column_pos_next = AW'(pos_x + XW'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos    <= '0;
      row_filter    <= FLT_NONE;
      on_first_row  <= 1'b1;
      expect_filter <= 1'b1;
      error_latched <= 1'b0;
    end else begin
      column_pos    <= column_pos_next;
      row_filter    <= row_filter_next;
      on_first_row  <= on_first_row_next;
      expect_filter <= expect_filter_next;
      error_latched <= error_latched_next;
    end
  end

  // stage 1 rebuild
  pix_byte_t a_nb, b_nb, c_nb, pred, val;
  logic [8:0] avg_sum;
  logic       bpp_is3;

  assign bpp_is3 = bpp <= 3'd3;
  assign a_nb    = bpp_is3 ? left_pixel[23:16] : left_pixel[31:24];
  assign c_nb    = bpp_is3 ? upper_left_pixel[23:16] : upper_left_pixel[31:24];
  assign b_nb    = s1_zero_b ? '0 : (s1_fwd ? s1_fwd_data : mem_q);
  assign avg_sum = {1'b0, a_nb} + {1'b0, b_nb};

  always_comb begin
    case (s1_filter)
      FLT_SUB:   pred = a_nb;
      FLT_UP:    pred = b_nb;
      FLT_AVG:   pred = avg_sum[8:1];
      FLT_PAETH: pred = paeth_pred(a_nb, b_nb, c_nb);
      default:   pred = '0;
    endcase
  end

  assign val     = s1_byte + pred;
  assign s1_move = s1_valid && (s1_kind == K_CLEAR || !out_valid || pixels.ready);
  assign s1_we   = s1_move && s1_kind == K_DATA;

  assign stream.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.ready) begin
      s1_valid <= stream.valid && ld_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_kind     <= ld_kind;
      s1_pos      <= pos_addr;
      s1_filter   <= row_filter;
      s1_zero_b   <= first_eff;
      s1_last     <= is_last;
      s1_byte     <= stream.byte_value;
      s1_fwd      <= rd_en && s1_we && s1_pos == pos_addr;
      s1_fwd_data <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_we) begin
      line_mem[s1_pos] <= val;
    end
    if (rd_en) begin
      mem_q <= line_mem[pos_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else if (s1_move) begin
      unique case (s1_kind)
        K_CLEAR: begin
          left_pixel       <= '0;
          upper_left_pixel <= '0;
        end
        K_DATA: begin
          left_pixel       <= {left_pixel[23:0], val};
          upper_left_pixel <= {upper_left_pixel[23:0], b_nb};
        end
        K_ERR: begin
          left_pixel       <= left_pixel;
          upper_left_pixel <= upper_left_pixel;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && s1_kind != K_CLEAR) begin
      out_valid <= 1'b1;
    end else if (pixels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_kind != K_CLEAR) begin
      out_byte <= (s1_kind == K_ERR) ? '0 : val;
      out_last <= (s1_kind == K_DATA) && s1_last;
      out_err  <= s1_kind == K_ERR;
    end
  end

  assign pixels.valid        = out_valid;
  assign pixels.pixel_byte   = out_byte;
  assign pixels.row_last     = out_last;
  assign pixels.filter_error = out_err;

  a_err_latch: assert property (@(posedge clk) disable iff (rst)
    acc && !err_eff && expf_eff && bad_flt |=> error_latched)
    else $error("bad filter type did not latch error");

  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    error_latched && !(acc && stream.image_start) |=> error_latched)
    else $error("error latch dropped without image start");

  a_row_end: assert property (@(posedge clk) disable iff (rst)
    acc && !err_eff && !expf_eff && is_last |=> expect_filter && column_pos == '0)
    else $error("row end did not rearm filter byte");

  a_fwd_data: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_fwd |-> s1_kind == K_DATA)
    else $error("forwarding set on a non-data item");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_pos) && $stable(s1_byte))
    else $error("stage 1 changed while stalled");

endmodule

`default_nettype wire
